@@ rtl/t2i64_pkg.sv @@
// Shared types and character codes for the text to int64 parser.
// Depends on nothing; used by rtl/text_to_int64_parser.sv.
`timescale 1ns / 1ps

package t2i64_pkg;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_ZERO  = 3'd2,
        PH_DIGIT = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_BIN = 2'd1,
        RX_OCT = 2'd2,
        RX_HEX = 2'd3
    } radix_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_B  = 8'h42;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_UC_O  = 8'h4F;
    localparam logic [7:0] CH_LC_O  = 8'h6F;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_LC_X  = 8'h78;

    // Marks a character that is no digit in any radix.
    localparam logic [5:0] DIGIT_NONE = 6'd63;

    localparam logic [67:0] MAG_LIMIT = {5'd0, 63'h7FFF_FFFF_FFFF_FFFF};
    localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VALUE_MIN = 64'h8000_0000_0000_0000;

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = {2'b00, DIGIT_NONE};
        if (c >= CH_ZERO && c <= CH_NINE)
            d = c - CH_ZERO;
        else if (c >= CH_LC_A && c <= CH_LC_Z)
            d = c - CH_LC_A + 8'd10;
        else if (c >= CH_UC_A && c <= CH_UC_Z)
            d = c - CH_UC_A + 8'd10;
        return d[5:0];
    endfunction

    function automatic logic [4:0] radix_value(input radix_t r);
        logic [4:0] v;
        unique case (r)
            RX_BIN:  v = 5'd2;
            RX_OCT:  v = 5'd8;
            RX_HEX:  v = 5'd16;
            default: v = 5'd10;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/text_to_int64_parser.sv @@
// Text to int64 parser: input register, combinational parse step, result register.
// Depends on rtl/t2i64_pkg.sv.
// A result appears on m_axis once the last byte has passed the input register and been written to the result register.
// Throughput: one byte per cycle, but a last byte waits while the result register is full; the
// single shift-add and limit compare on the accumulated magnitude sets that figure.
// Reset (rst_n low, asynchronous) empties both registers and returns the parser to
// the leading whitespace phase.
`timescale 1ns / 1ps

module text_to_int64_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tuser,   // [0] has_char
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] value (signed)
    output logic        m_axis_tuser    // [0] saturated
);

    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_has_reg;
    logic        in_last_reg;

    t2i64_pkg::phase_t phase_reg, phase_next;
    t2i64_pkg::radix_t radix_reg, radix_next;
    logic        neg_reg, neg_next;
    logic [62:0] mag_reg, mag_next;
    logic        ovf_reg, ovf_next;

    logic        out_valid_reg;
    logic [63:0] out_value_reg, out_value_next;
    logic        out_sat_reg;

    logic        out_free;
    logic        step;
    logic [5:0]  digit;
    logic [4:0]  radix;
    logic        digit_ok;
    logic [67:0] product;
    logic [67:0] sum;
    logic        would_ovf;
    logic        is_space;
    logic [63:0] mag_ext;

    assign out_free      = !out_valid_reg || m_axis_tready;
    // Only a last byte needs room in the result register.
    assign step          = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || step;

    assign digit    = t2i64_pkg::digit_of(in_char_reg);
    assign radix    = t2i64_pkg::radix_value(radix_reg);
    assign digit_ok = {1'b0, digit} < {2'b00, radix};

    always_comb
    begin
        unique case (radix_reg)
            t2i64_pkg::RX_BIN: product = {4'd0, mag_reg, 1'b0};
            t2i64_pkg::RX_OCT: product = {2'd0, mag_reg, 3'b000};
            t2i64_pkg::RX_HEX: product = {1'b0, mag_reg, 4'b0000};
            default:           product = {2'd0, mag_reg, 3'b000} + {4'd0, mag_reg, 1'b0};
        endcase
    end

    assign sum       = product + {62'd0, digit};
    assign would_ovf = sum > t2i64_pkg::MAG_LIMIT;
    assign is_space  = (in_char_reg == t2i64_pkg::CH_SPACE) ||
                       (in_char_reg >= t2i64_pkg::CH_TAB && in_char_reg <= t2i64_pkg::CH_CR);

    // Next parser state for the byte held in the input register.
    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        if (in_has_reg)
        begin
            unique case (phase_reg)
                t2i64_pkg::PH_LEAD, t2i64_pkg::PH_SIGN:
                begin
                    if (phase_reg == t2i64_pkg::PH_LEAD && is_space)
                    begin
                        phase_next = t2i64_pkg::PH_LEAD;
                    end
                    else if (phase_reg == t2i64_pkg::PH_LEAD &&
                             (in_char_reg == t2i64_pkg::CH_MINUS ||
                              in_char_reg == t2i64_pkg::CH_PLUS))
                    begin
                        neg_next   = (in_char_reg == t2i64_pkg::CH_MINUS);
                        phase_next = t2i64_pkg::PH_SIGN;
                    end
                    else if (in_char_reg == t2i64_pkg::CH_ZERO)
                    begin
                        phase_next = t2i64_pkg::PH_ZERO;
                    end
                    else if (!digit_ok)
                    begin
                        phase_next = t2i64_pkg::PH_DONE;
                    end
                    else if (would_ovf)
                    begin
                        ovf_next   = 1'b1;
                        phase_next = t2i64_pkg::PH_DONE;
                    end
                    else
                    begin
                        mag_next   = sum[62:0];
                        phase_next = t2i64_pkg::PH_DIGIT;
                    end
                end
                t2i64_pkg::PH_ZERO, t2i64_pkg::PH_DIGIT:
                begin
                    if (phase_reg == t2i64_pkg::PH_ZERO &&
                        (in_char_reg == t2i64_pkg::CH_LC_B || in_char_reg == t2i64_pkg::CH_UC_B))
                    begin
                        radix_next = t2i64_pkg::RX_BIN;
                        phase_next = t2i64_pkg::PH_DIGIT;
                    end
                    else if (phase_reg == t2i64_pkg::PH_ZERO &&
                             (in_char_reg == t2i64_pkg::CH_LC_X ||
                              in_char_reg == t2i64_pkg::CH_UC_X))
                    begin
                        radix_next = t2i64_pkg::RX_HEX;
                        phase_next = t2i64_pkg::PH_DIGIT;
                    end
                    else if (phase_reg == t2i64_pkg::PH_ZERO &&
                             (in_char_reg == t2i64_pkg::CH_LC_O ||
                              in_char_reg == t2i64_pkg::CH_UC_O))
                    begin
                        radix_next = t2i64_pkg::RX_OCT;
                        phase_next = t2i64_pkg::PH_DIGIT;
                    end
                    else if (!digit_ok)
                    begin
                        phase_next = t2i64_pkg::PH_DONE;
                    end
                    else if (would_ovf)
                    begin
                        ovf_next   = 1'b1;
                        phase_next = t2i64_pkg::PH_DONE;
                    end
                    else
                    begin
                        mag_next   = sum[62:0];
                        phase_next = t2i64_pkg::PH_DIGIT;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result value from the state after this byte.
    assign mag_ext = {1'b0, mag_next};

    always_comb
    begin
        if (ovf_next)
            out_value_next = neg_next ? t2i64_pkg::VALUE_MIN : t2i64_pkg::VALUE_MAX;
        else
            out_value_next = neg_next ? (~mag_ext + 64'd1) : mag_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_has_reg  <= s_axis_tuser;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= t2i64_pkg::PH_LEAD;
            radix_reg <= t2i64_pkg::RX_DEC;
            neg_reg   <= 1'b0;
            mag_reg   <= 63'd0;
            ovf_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (in_last_reg)
            begin
                phase_reg <= t2i64_pkg::PH_LEAD;
                radix_reg <= t2i64_pkg::RX_DEC;
                neg_reg   <= 1'b0;
                mag_reg   <= 63'd0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                neg_reg   <= neg_next;
                mag_reg   <= mag_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_last_reg)
        begin
            out_value_reg <= out_value_next;
            out_sat_reg   <= ovf_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_sat_reg;

endmodule
